// ===== rtl/bsk_pkg.sv =====
// Shared types and constants for the block skewness and kurtosis engine.
`default_nettype none

package bsk_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS   = 12;
    localparam int MEAN_W      = 16;
    localparam int STD_W       = 16;
    localparam int Z_W         = 20;
    localparam int SQ_W        = 27;
    localparam int CUBE_W      = 34;
    localparam int FOUR_W      = 41;
    localparam int ACC_W       = 48;
    localparam int OUT_W       = 32;
    localparam int COUNT_OUT_W = 13;
    localparam int M_DATA_W    = 80;
    localparam int PADDR_W     = 3;
    localparam int ROUND_HALF  = 2048;
    localparam int KURT_OFFSET = 12288;
    localparam int MUL_DIGIT   = 4;

    // Saturation limits of the standardized magnitude.
    localparam logic [Z_W-1:0] Z_POS_LIM = 20'h7_FFFF;
    localparam logic [Z_W-1:0] Z_NEG_LIM = 20'h8_0000;

    // Accumulator and result limits.
    localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    // Register word indexes.
    localparam logic REG_MEAN = 1'b0;
    localparam logic REG_STD  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ZDIV,
        ST_SQ_GO,
        ST_SQ,
        ST_POW_GO,
        ST_POW,
        ST_ACC,
        ST_FDIV_GO,
        ST_FDIV,
        ST_RES
    } bsk_state_t;

endpackage

`default_nettype wire

// ===== rtl/block_skewness_kurtosis.sv =====
// Samples transfer only in the idle state, so a new sample waits until the last one is through:
// it is centered at its transfer, divided by std for z, squared, then raised to the cube and
// fourth power by two multipliers in parallel, and added to the sums. A last sample then runs
// the two final divides, and its result is loaded into the output register once that is free;
// a stalled output delays both the result and the next sample. A sample that meets a full block skips the math.
// Reset clears the sums, the count, the output valid flag and sets mean 0, std 1.
`default_nettype none

module block_skewness_kurtosis import bsk_pkg::*; #(
    parameter int MAX_BLOCK   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [PADDR_W-1:0]                  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Sample stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
    input  logic                                s_tlast,  // last_sample
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [M_DATA_W-1:0]                 m_tdata   // skewness, excess_kurtosis, sample_count
);

    localparam int D_W    = ((SAMPLE_BITS > MEAN_W) ? SAMPLE_BITS : MEAN_W) + 1;
    localparam int NZ_W   = D_W + FRAC_BITS;
    localparam int ZCMP_W = NZ_W - Z_W + STD_W;
    localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
    localparam int FCMP_W = ACC_W + 1 - OUT_W + CNT_W;

    // Saturating add into a 48-bit accumulator.
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W:0]   addend);
        logic [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + addend;
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    bsk_state_t state_reg;
    bsk_state_t state_next;

    logic [MEAN_W-1:0]      mean_reg;
    logic [STD_W-1:0]       std_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [ACC_W-1:0]       cube_sum_reg;
    logic [ACC_W-1:0]       four_sum_reg;
    logic [D_W-1:0]         d_reg;
    logic                   last_reg;
    logic                   z_ovf_reg;
    logic [Z_W-1:0]         m_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [CUBE_W-1:0]      cube_term_reg;
    logic [FOUR_W-1:0]      four_term_reg;
    logic                   cneg_reg;
    logic                   kneg_reg;
    logic                   covf_reg;
    logic                   kovf_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       skew_out_reg;
    logic [OUT_W-1:0]       kurt_out_reg;
    logic [COUNT_OUT_W-1:0] cnt_out_reg;

    logic                   cfg_write;
    logic                   full;
    logic                   out_free;
    logic                   zdiv_start;
    logic                   sq_start;
    logic                   pow_start;
    logic                   fdiv_start;
    logic                   res_load;

    logic [SAMPLE_BITS-1:0] samp;
    logic [D_W-1:0]         d_next;
    logic [STD_W-1:0]       den;
    logic [NZ_W:0]          dsh;
    logic [NZ_W:0]          nz_full;
    logic [NZ_W-1:0]        nz;
    logic                   z_ovf;
    logic [Z_W-1:0]         zq;
    logic                   zdiv_done;
    logic [Z_W-1:0]         z_lim;
    logic [Z_W-1:0]         m_next;

    logic [2*Z_W-1:0]       p_sq;
    logic                   sq_done;
    logic [2*Z_W:0]         sq_rnd;
    logic [SQ_W+Z_W-1:0]    p_cube;
    logic                   cube_done;
    logic [SQ_W+Z_W:0]      cube_rnd;
    logic [2*SQ_W-1:0]      p_four;
    logic                   four_done;
    logic [2*SQ_W:0]        four_rnd;
    logic [ACC_W:0]         cube_add;

    logic [CNT_W-1:0]       n;
    logic [ACC_W:0]         n_half;
    logic [ACC_W:0]         cnum;
    logic [ACC_W:0]         knum;
    logic                   covf;
    logic                   kovf;
    logic [OUT_W-1:0]       cq;
    logic [OUT_W-1:0]       kq;
    logic                   cdiv_done;
    logic                   kdiv_done;
    logic [OUT_W+1:0]       kval;
    logic [OUT_W-1:0]       skew_next;
    logic [OUT_W-1:0]       kurt_next;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

    // Configuration registers, decoded by word index.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            std_reg  <= STD_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MEAN: mean_reg <= pwdata[MEAN_W-1:0];
                REG_STD:  std_reg  <= pwdata[STD_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MEAN: prdata = {{(32-MEAN_W){mean_reg[MEAN_W-1]}}, mean_reg};
            REG_STD:  prdata = 32'(std_reg);
            default:  prdata = '0;
        endcase
    end

    // Centering of the incoming sample.
    assign samp   = s_tdata[SAMPLE_BITS-1:0];
    assign d_next = {{(D_W-SAMPLE_BITS){samp[SAMPLE_BITS-1]}}, samp}
                  - {{(D_W-MEAN_W){mean_reg[MEAN_W-1]}}, mean_reg};

    // Rounded numerator |d| * 4096 + den/2 and the early saturation check.
    assign den     = (std_reg == '0) ? STD_W'(1) : std_reg;
    assign dsh     = {d_reg[D_W-1], d_reg, {FRAC_BITS{1'b0}}};
    assign nz_full = d_reg[D_W-1] ? ((NZ_W+1)'(den >> 1) - dsh)
                                  : (dsh + (NZ_W+1)'(den >> 1));
    assign nz      = nz_full[NZ_W-1:0];
    assign z_ovf   = ZCMP_W'(nz[NZ_W-1:Z_W]) >= ZCMP_W'(den);

    bsk_div #(
        .NUM_W (NZ_W),
        .DEN_W (STD_W),
        .Q_W   (Z_W)
    ) u_zdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (zdiv_start),
        .num   (nz),
        .den   (den),
        .done  (zdiv_done),
        .quot  (zq)
    );

    // Standardized magnitude, saturated to Q8.12.
    assign z_lim  = d_reg[D_W-1] ? Z_NEG_LIM : Z_POS_LIM;
    assign m_next = (z_ovf_reg || (zq > z_lim)) ? z_lim : zq;

    bsk_mul #(
        .A_W (Z_W),
        .B_W (Z_W)
    ) u_mul_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .a       (m_reg),
        .b       (m_reg),
        .done    (sq_done),
        .product (p_sq)
    );

    bsk_mul #(
        .A_W (SQ_W),
        .B_W (Z_W)
    ) u_mul_cube (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pow_start),
        .a       (sq_reg),
        .b       (m_reg),
        .done    (cube_done),
        .product (p_cube)
    );

    bsk_mul #(
        .A_W (SQ_W),
        .B_W (SQ_W)
    ) u_mul_four (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (pow_start),
        .a       (sq_reg),
        .b       (sq_reg),
        .done    (four_done),
        .product (p_four)
    );

    // Round each product back to Q.12.
    assign sq_rnd   = {1'b0, p_sq} + (2*Z_W+1)'(ROUND_HALF);
    assign cube_rnd = {1'b0, p_cube} + (SQ_W+Z_W+1)'(ROUND_HALF);
    assign four_rnd = {1'b0, p_four} + (2*SQ_W+1)'(ROUND_HALF);
    assign cube_add = d_reg[D_W-1] ? -((ACC_W+1)'(cube_term_reg))
                                   : (ACC_W+1)'(cube_term_reg);

    // Final rounded numerators and the early saturation check.
    assign full   = (count_reg == CNT_W'(MAX_BLOCK));
    assign n      = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign n_half = (ACC_W+1)'(n >> 1);
    assign cnum   = cube_sum_reg[ACC_W-1] ? (n_half - {cube_sum_reg[ACC_W-1], cube_sum_reg})
                                          : ({cube_sum_reg[ACC_W-1], cube_sum_reg} + n_half);
    assign knum   = four_sum_reg[ACC_W-1] ? (n_half - {four_sum_reg[ACC_W-1], four_sum_reg})
                                          : ({four_sum_reg[ACC_W-1], four_sum_reg} + n_half);
    assign covf   = FCMP_W'(cnum[ACC_W:OUT_W]) >= FCMP_W'(n);
    assign kovf   = FCMP_W'(knum[ACC_W:OUT_W]) >= FCMP_W'(n);

    bsk_div #(
        .NUM_W (ACC_W + 1),
        .DEN_W (CNT_W),
        .Q_W   (OUT_W)
    ) u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fdiv_start),
        .num   (cnum),
        .den   (n),
        .done  (cdiv_done),
        .quot  (cq)
    );

    bsk_div #(
        .NUM_W (ACC_W + 1),
        .DEN_W (CNT_W),
        .Q_W   (OUT_W)
    ) u_kdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fdiv_start),
        .num   (knum),
        .den   (n),
        .done  (kdiv_done),
        .quot  (kq)
    );

    // Signed results with saturation to 32 bits.
    always_comb
    begin
        if (!cneg_reg)
            skew_next = (covf_reg || cq[OUT_W-1]) ? OUT_MAX : cq;
        else
            skew_next = (covf_reg || (cq > OUT_MIN)) ? OUT_MIN : -cq;

        kval = kneg_reg ? (-(OUT_W+2)'(kq) - (OUT_W+2)'(KURT_OFFSET))
                        : ((OUT_W+2)'(kq) - (OUT_W+2)'(KURT_OFFSET));
        if (kovf_reg)
            kurt_next = kneg_reg ? OUT_MIN : OUT_MAX;
        else if ((kval[OUT_W+1] == kval[OUT_W]) && (kval[OUT_W] == kval[OUT_W-1]))
            kurt_next = kval[OUT_W-1:0];
        else
            kurt_next = kval[OUT_W+1] ? OUT_MIN : OUT_MAX;
    end

    assign cnt_ext  = (CNT_W + COUNT_OUT_W)'(count_reg);
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_PREP;
            ST_PREP:
            begin
                if (!full)
                    state_next = ST_ZDIV;
                else if (last_reg)
                    state_next = ST_FDIV_GO;
                else
                    state_next = ST_IDLE;
            end
            ST_ZDIV:    if (zdiv_done) state_next = ST_SQ_GO;
            ST_SQ_GO:   state_next = ST_SQ;
            ST_SQ:      if (sq_done) state_next = ST_POW_GO;
            ST_POW_GO:  state_next = ST_POW;
            ST_POW:     if (four_done) state_next = ST_ACC;
            ST_ACC:     state_next = last_reg ? ST_FDIV_GO : ST_IDLE;
            ST_FDIV_GO: state_next = ST_FDIV;
            ST_FDIV:    if (cdiv_done) state_next = ST_RES;
            ST_RES:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready   = 1'b0;
        zdiv_start = 1'b0;
        sq_start   = 1'b0;
        pow_start  = 1'b0;
        fdiv_start = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_tready   = 1'b1;
            ST_PREP:    zdiv_start = !full;
            ST_SQ_GO:   sq_start   = 1'b1;
            ST_POW_GO:  pow_start  = 1'b1;
            ST_FDIV_GO: fdiv_start = 1'b1;
            ST_RES:     res_load   = out_free;
            default:    ;
        endcase
    end

    // Count and saturating sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cube_sum_reg <= '0;
            four_sum_reg <= '0;
        end
        else if (res_load)
        begin
            count_reg    <= '0;
            cube_sum_reg <= '0;
            four_sum_reg <= '0;
        end
        else if (state_reg == ST_ACC)
        begin
            count_reg    <= count_reg + 1'b1;
            cube_sum_reg <= sat_add(cube_sum_reg, cube_add);
            four_sum_reg <= sat_add(four_sum_reg, (ACC_W+1)'(four_term_reg));
        end
    end

    // Per-sample working registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            d_reg    <= d_next;
            last_reg <= s_tlast;
        end
        if (zdiv_start)
            z_ovf_reg <= z_ovf;
        if ((state_reg == ST_ZDIV) && zdiv_done)
            m_reg <= m_next;
        if ((state_reg == ST_SQ) && sq_done)
            sq_reg <= sq_rnd[FRAC_BITS +: SQ_W];
        if ((state_reg == ST_POW) && four_done)
        begin
            cube_term_reg <= cube_rnd[FRAC_BITS +: CUBE_W];
            four_term_reg <= four_rnd[FRAC_BITS +: FOUR_W];
        end
        if (fdiv_start)
        begin
            cneg_reg <= cube_sum_reg[ACC_W-1];
            kneg_reg <= four_sum_reg[ACC_W-1];
            covf_reg <= covf;
            kovf_reg <= kovf;
        end
    end

    // Output register; holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            skew_out_reg <= skew_next;
            kurt_out_reg <= kurt_next;
            cnt_out_reg  <= cnt_ext[COUNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({cnt_out_reg, kurt_out_reg, skew_out_reg});

`ifndef ASSERT_OFF
    // A transfer in always moves the sequencer to the preparation step.
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted sample did not start processing");

    // The cube product, having fewer digits, finishes while the fourth power still runs.
    a_cube_first: assert property (@(posedge clk) disable iff (!rst_n)
        cube_done |-> ((state_reg == ST_POW) && !four_done))
        else $error("cube multiplier finished out of step");

    // The two final dividers run in lockstep.
    a_fdiv_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        kdiv_done == cdiv_done)
        else $error("final dividers out of step");

    // Loading a result presents it and clears the block state.
    a_res_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (m_tvalid && (count_reg == '0) && (cube_sum_reg == '0)))
        else $error("result load did not clear the block");
`endif

endmodule

`default_nettype wire

// ===== rtl/bsk_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module bsk_div import bsk_pkg::*; #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int Q_W   = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quot
);

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0]       den_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [Q_W-1:0]         bits_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   done_reg;
    logic [NUM_W+DEN_W-1:0] num_ext;
    logic [DEN_W:0]         trial;
    logic [DEN_W:0]         diff;
    logic                   fits;

    // The caller guarantees num / 2^Q_W < den, so the upper part starts as the remainder.
    assign num_ext = (NUM_W + DEN_W)'(num);
    assign trial   = {rem_reg, bits_reg[Q_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign fits    = trial >= {1'b0, den_reg};

    // One trial subtraction per cycle; quotient bits shift in from the bottom.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(Q_W);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= num_ext[Q_W +: DEN_W];
            bits_reg <= num[Q_W-1:0];
        end
        else if (step_reg != '0)
        begin
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            bits_reg <= {bits_reg[Q_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = bits_reg;

endmodule

`default_nettype wire

// ===== rtl/bsk_mul.sv =====
// Digit-serial multiplier that consumes one 4-bit digit of the multiplier per cycle.
`default_nettype none

module bsk_mul import bsk_pkg::*; #(
    parameter int A_W = 20,
    parameter int B_W = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int STEPS  = (B_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BP_W   = STEPS * MUL_DIGIT;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [A_W-1:0]           a_reg;
    logic [BP_W-1:0]          b_reg;
    logic [A_W-1:0]           hi_reg;
    logic [BP_W-1:0]          lo_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     done_reg;
    logic [A_W+MUL_DIGIT-1:0] partial;
    logic [A_W+MUL_DIGIT-1:0] sum;
    logic [A_W+BP_W-1:0]      full;

    // Partial product of the multiplicand and the lowest remaining digit.
    assign partial = (A_W + MUL_DIGIT)'(a_reg) * (A_W + MUL_DIGIT)'(b_reg[MUL_DIGIT-1:0]);
    assign sum     = partial + (A_W + MUL_DIGIT)'(hi_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(STEPS);
            done_reg <= 1'b0;
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - 1'b1;
            done_reg <= (step_reg == STEP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Low digits of each sum retire into the low half of the product.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= BP_W'(b);
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (step_reg != '0)
        begin
            b_reg  <= b_reg >> MUL_DIGIT;
            hi_reg <= sum[MUL_DIGIT +: A_W];
            lo_reg <= {sum[MUL_DIGIT-1:0], lo_reg[BP_W-1:MUL_DIGIT]};
        end
    end

    assign full    = {hi_reg, lo_reg};
    assign done    = done_reg;
    assign product = full[A_W+B_W-1:0];

endmodule

`default_nettype wire
